/* src/complex_arithmetic_unit_defines.svh */
// assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define CAU_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication
`define CAU_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

/* src/cau_pkg.sv */
// shared types and constants of the complex arithmetic unit
package cau_pkg;
   localparam int FUNC_BITS = 3;
   localparam int EXP_BITS = 8;
   localparam int STATUS_BITS = 2;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_ADD = 3'd0,
      FUNC_SUB = 3'd1,
      FUNC_MUL = 3'd2,
      FUNC_DIV = 3'd3,
      FUNC_POW = 3'd4
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK = 2'd0,
      STATUS_OVF = 2'd1,
      STATUS_DIV0 = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_MUL,
      OP_DIV,
      OP_POW
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_MUL_D,
      ST_MUL_SUM,
      ST_DEN,
      ST_DIV_RE,
      ST_DIV_IM,
      ST_DIV_FIX,
      ST_DONE
   } state_type;
endpackage

/* src/cau_if.sv */
// valid/ready channel interface
interface cau_if #(
   parameter type payload_type = logic
);
   logic valid;
   logic ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* src/cau_front.sv */
// front end: accepts requests, computes add and subtract results, queues every request
module cau_front #(
   parameter int WORD_BITS = 32,
   parameter int MAX_EXPONENT = 255,
   parameter int EW = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [cau_pkg::FUNC_BITS-1:0] in_func,
   input  logic signed [WORD_BITS-1:0] in_ar,
   input  logic signed [WORD_BITS-1:0] in_ai,
   input  logic signed [WORD_BITS-1:0] in_br,
   input  logic signed [WORD_BITS-1:0] in_bi,
   input  logic [cau_pkg::EXP_BITS-1:0] in_exp,
   output logic q_valid,
   input  logic q_ready,
   output cau_pkg::op_type q_op,
   output logic signed [WORD_BITS-1:0] q_ar,
   output logic signed [WORD_BITS-1:0] q_ai,
   output logic signed [WORD_BITS-1:0] q_br,
   output logic signed [WORD_BITS-1:0] q_bi,
   output logic [EW-1:0] q_exp,
   output logic signed [WORD_BITS-1:0] q_rr,
   output logic signed [WORD_BITS-1:0] q_ri,
   output logic [cau_pkg::STATUS_BITS-1:0] q_st
);
   localparam int DEPTH = 2;
   localparam logic signed [WORD_BITS:0] MAXV = (WORD_BITS+1)'((64'sd1 <<< (WORD_BITS-1)) - 1);
   localparam logic signed [WORD_BITS:0] MINV = -MAXV - 1;

   cau_pkg::op_type op_m [DEPTH];
   logic signed [WORD_BITS-1:0] ar_m [DEPTH], ai_m [DEPTH], br_m [DEPTH], bi_m [DEPTH];
   logic signed [WORD_BITS-1:0] rr_m [DEPTH], ri_m [DEPTH];
   logic [EW-1:0] exp_m [DEPTH];
   logic [cau_pkg::STATUS_BITS-1:0] st_m [DEPTH];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   logic signed [WORD_BITS:0] sr, si;
   logic signed [WORD_BITS-1:0] cr, ci;
   logic ovr, ovi;
   cau_pkg::op_type op;
   logic [EW-1:0] ex;

   always_comb begin
      if (in_func == cau_pkg::FUNC_SUB) begin
         sr = {in_ar[WORD_BITS-1], in_ar} - {in_br[WORD_BITS-1], in_br};
         si = {in_ai[WORD_BITS-1], in_ai} - {in_bi[WORD_BITS-1], in_bi};
      end else begin
         sr = {in_ar[WORD_BITS-1], in_ar} + {in_br[WORD_BITS-1], in_br};
         si = {in_ai[WORD_BITS-1], in_ai} + {in_bi[WORD_BITS-1], in_bi};
      end
      ovr = (sr > MAXV) || (sr < MINV);
      ovi = (si > MAXV) || (si < MINV);
      cr = ovr ? (sr[WORD_BITS] ? MINV[WORD_BITS-1:0] : MAXV[WORD_BITS-1:0]) : sr[WORD_BITS-1:0];
      ci = ovi ? (si[WORD_BITS] ? MINV[WORD_BITS-1:0] : MAXV[WORD_BITS-1:0]) : si[WORD_BITS-1:0];
      ex = (EW'(in_exp) > EW'(MAX_EXPONENT)) ? EW'(MAX_EXPONENT) : EW'(in_exp);
      case (in_func)
         cau_pkg::FUNC_ADD, cau_pkg::FUNC_SUB: op = cau_pkg::OP_NONE;
         cau_pkg::FUNC_MUL: op = cau_pkg::OP_MUL;
         cau_pkg::FUNC_DIV: op = cau_pkg::OP_DIV;
         cau_pkg::FUNC_POW: op = cau_pkg::OP_POW;
         default: op = cau_pkg::OP_NONE;
      endcase
   end

   logic is_as;
   assign is_as = (in_func == cau_pkg::FUNC_ADD) || (in_func == cau_pkg::FUNC_SUB);
   assign in_ready = (cnt_ff != 2'(DEPTH));
   assign q_valid = (cnt_ff != 2'd0);
   assign q_op = op_m[rp_ff];
   assign q_ar = ar_m[rp_ff];
   assign q_ai = ai_m[rp_ff];
   assign q_br = br_m[rp_ff];
   assign q_bi = bi_m[rp_ff];
   assign q_exp = exp_m[rp_ff];
   assign q_rr = rr_m[rp_ff];
   assign q_ri = ri_m[rp_ff];
   assign q_st = st_m[rp_ff];

   logic push, pop;
   assign push = in_valid && in_ready;
   assign pop = q_valid && q_ready;

   always_comb begin
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_m[wp_ff] <= op;
         ar_m[wp_ff] <= in_ar;
         ai_m[wp_ff] <= in_ai;
         br_m[wp_ff] <= in_br;
         bi_m[wp_ff] <= in_bi;
         exp_m[wp_ff] <= ex;
         rr_m[wp_ff] <= is_as ? cr : '0;
         ri_m[wp_ff] <= is_as ? ci : '0;
         st_m[wp_ff] <= (is_as && (ovr || ovi)) ? cau_pkg::STATUS_OVF : cau_pkg::STATUS_OK;
      end
   end
endmodule

/* src/cau_divider.sv */
// unsigned restoring divider, one quotient bit a cycle
module cau_divider #(
   parameter int NW = 96,
   parameter int DW = 65
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic busy,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0] r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] c_ff, c_in;
   logic [DW:0] trial;

   assign busy = (c_ff != '0);
   assign quo = q_ff;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      c_in = c_ff;
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         c_in = CW'(NW);
      end else if (busy) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         c_in = c_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff <= '0;
      end else begin
         c_ff <= c_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end
endmodule

/* src/cau_back.sv */
// back end: shared multiplier sequencer, divider and output register
module cau_back #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16,
   parameter int EW = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_ready,
   input  cau_pkg::op_type q_op,
   input  logic signed [WORD_BITS-1:0] q_ar,
   input  logic signed [WORD_BITS-1:0] q_ai,
   input  logic signed [WORD_BITS-1:0] q_br,
   input  logic signed [WORD_BITS-1:0] q_bi,
   input  logic [EW-1:0] q_exp,
   input  logic signed [WORD_BITS-1:0] q_rr,
   input  logic signed [WORD_BITS-1:0] q_ri,
   input  logic [cau_pkg::STATUS_BITS-1:0] q_st,
   output logic out_valid,
   input  logic out_ready,
   output logic signed [WORD_BITS-1:0] out_rr,
   output logic signed [WORD_BITS-1:0] out_ri,
   output logic [cau_pkg::STATUS_BITS-1:0] out_st
);
   localparam int PW = 2 * WORD_BITS;
   localparam int SW = PW + 1;
   localparam int NW = SW + FRAC_BITS;
   localparam logic signed [WORD_BITS-1:0] MAXW = WORD_BITS'((64'sd1 <<< (WORD_BITS-1)) - 1);
   localparam logic signed [WORD_BITS-1:0] MINW = ~MAXW;
   localparam logic signed [SW-1:0] ONE_W = SW'(64'sd1) <<< FRAC_BITS;

   function automatic logic signed [WORD_BITS-1:0] clampw(input logic signed [NW:0] v,
                                                           output logic o);
      logic signed [NW:0] hi, lo;
      hi = (NW+1)'(MAXW);
      lo = (NW+1)'(MINW);
      o = 1'b0;
      if (v > hi) begin
         o = 1'b1;
         clampw = MAXW;
      end else if (v < lo) begin
         o = 1'b1;
         clampw = MINW;
      end else begin
         clampw = v[WORD_BITS-1:0];
      end
   endfunction

   cau_pkg::state_type state_ff, state_in;
   cau_pkg::op_type op_ff, op_in;
   logic signed [WORD_BITS-1:0] ar_ff, ai_ff, br_ff, bi_ff, ar_in, ai_in, br_in, bi_in;
   logic signed [WORD_BITS-1:0] xr_ff, xi_ff, xr_in, xi_in;
   logic [EW-1:0] cnt_ff, cnt_in;
   logic signed [PW-1:0] p_ff, p_in;
   logic signed [SW-1:0] s0_ff, s0_in, s1_ff, s1_in, den_ff, den_in;
   logic ovf_ff, ovf_in, nre_ff, nre_in, nim_ff, nim_in;
   logic signed [WORD_BITS-1:0] qre_ff, qre_in;
   logic ov_ff, ov_in;
   logic signed [WORD_BITS-1:0] orr_ff, orr_in, ori_ff, ori_in;
   logic [cau_pkg::STATUS_BITS-1:0] ost_ff, ost_in;

   logic signed [WORD_BITS-1:0] ma, mb;
   logic signed [PW-1:0] prod;
   logic div_start, div_busy;
   logic [NW-1:0] div_num, div_quo;
   logic [SW-1:0] div_den;
   logic signed [NW:0] qs;
   logic signed [WORD_BITS-1:0] cr, ci, cq;
   logic o1, o2, o3;
   logic signed [SW-1:0] sh_re, sh_im;

   assign prod = ma * mb;

   cau_divider #(.NW(NW), .DW(SW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .busy(div_busy), .quo(div_quo)
   );

   assign out_valid = (state_ff == cau_pkg::ST_DONE);
   assign out_rr = orr_ff;
   assign out_ri = ori_ff;
   assign out_st = ost_ff;
   assign div_den = den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cau_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in; ar_ff <= ar_in; ai_ff <= ai_in; br_ff <= br_in; bi_ff <= bi_in;
      xr_ff <= xr_in; xi_ff <= xi_in; cnt_ff <= cnt_in; p_ff <= p_in;
      s0_ff <= s0_in; s1_ff <= s1_in; den_ff <= den_in; ovf_ff <= ovf_in;
      nre_ff <= nre_in; nim_ff <= nim_in; qre_ff <= qre_in; ov_ff <= ov_in;
      orr_ff <= orr_in; ori_ff <= ori_in; ost_ff <= ost_in;
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; ar_in = ar_ff; ai_in = ai_ff; br_in = br_ff; bi_in = bi_ff;
      xr_in = xr_ff; xi_in = xi_ff; cnt_in = cnt_ff; p_in = p_ff;
      s0_in = s0_ff; s1_in = s1_ff; den_in = den_ff; ovf_in = ovf_ff;
      nre_in = nre_ff; nim_in = nim_ff; qre_in = qre_ff; ov_in = ov_ff;
      orr_in = orr_ff; ori_in = ori_ff; ost_in = ost_ff;
      q_ready = 1'b0;
      ma = xr_ff; mb = br_ff;
      div_start = 1'b0;
      div_num = '0;
      sh_re = s0_ff >>> FRAC_BITS;
      sh_im = s1_ff >>> FRAC_BITS;
      cr = clampw((NW+1)'(sh_re), o1);
      ci = clampw((NW+1)'(sh_im), o2);
      qs = $signed({1'b0, div_quo});
      cq = clampw((nre_ff ? -qs : qs), o3);
      case (state_ff)
         cau_pkg::ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               op_in = q_op;
               ovf_in = 1'b0;
               xr_in = q_ar; xi_in = q_ai;
               case (q_op)
                  cau_pkg::OP_MUL, cau_pkg::OP_DIV: begin
                     ar_in = q_ar; ai_in = q_ai; br_in = q_br; bi_in = q_bi;
                     state_in = (q_op == cau_pkg::OP_DIV) ? cau_pkg::ST_DEN : cau_pkg::ST_MUL_A;
                     cnt_in = '0;
                  end
                  cau_pkg::OP_POW: begin
                     ar_in = q_ar; ai_in = q_ai; br_in = q_ar; bi_in = q_ai;
                     if (q_exp == '0) begin
                        orr_in = clampw((NW+1)'(ONE_W), o1);
                        ori_in = '0;
                        ost_in = o1 ? cau_pkg::STATUS_OVF : cau_pkg::STATUS_OK;
                        state_in = cau_pkg::ST_DONE;
                     end else if (q_exp == EW'(1)) begin
                        orr_in = q_ar; ori_in = q_ai;
                        ost_in = cau_pkg::STATUS_OK;
                        state_in = cau_pkg::ST_DONE;
                     end else begin
                        cnt_in = q_exp - EW'(1);
                        state_in = cau_pkg::ST_MUL_A;
                     end
                  end
                  default: begin
                     orr_in = q_rr; ori_in = q_ri; ost_in = q_st;
                     state_in = cau_pkg::ST_DONE;
                  end
               endcase
            end
         end
         // den = br*br + bi*bi, then numerators via the shared product steps
         cau_pkg::ST_DEN: begin
            if (cnt_ff == '0) begin
               ma = br_ff; mb = br_ff;
               s0_in = SW'(prod);
               cnt_in = EW'(1);
            end else begin
               ma = bi_ff; mb = bi_ff;
               den_in = s0_ff + SW'(prod);
               xr_in = ar_ff; xi_in = ai_ff;
               state_in = cau_pkg::ST_MUL_A;
            end
         end
         cau_pkg::ST_MUL_A: begin
            ma = xr_ff; mb = br_ff;
            p_in = prod;
            state_in = cau_pkg::ST_MUL_B;
         end
         cau_pkg::ST_MUL_B: begin
            ma = xi_ff; mb = bi_ff;
            s0_in = (op_ff == cau_pkg::OP_DIV) ? SW'(p_ff) + SW'(prod) : SW'(p_ff) - SW'(prod);
            state_in = cau_pkg::ST_MUL_C;
         end
         cau_pkg::ST_MUL_C: begin
            ma = xr_ff; mb = bi_ff;
            p_in = prod;
            state_in = cau_pkg::ST_MUL_D;
         end
         cau_pkg::ST_MUL_D: begin
            ma = xi_ff; mb = br_ff;
            s1_in = (op_ff == cau_pkg::OP_DIV) ? SW'(prod) - SW'(p_ff) : SW'(p_ff) + SW'(prod);
            state_in = cau_pkg::ST_MUL_SUM;
         end
         cau_pkg::ST_MUL_SUM: begin
            if (op_ff == cau_pkg::OP_DIV) begin
               if (den_ff == '0) begin
                  orr_in = '0; ori_in = '0; ost_in = cau_pkg::STATUS_DIV0;
                  state_in = cau_pkg::ST_DONE;
               end else begin
                  nre_in = s0_ff[SW-1];
                  nim_in = s1_ff[SW-1];
                  div_start = 1'b1;
                  div_num = NW'(s0_ff[SW-1] ? -s0_ff : s0_ff) << FRAC_BITS;
                  state_in = cau_pkg::ST_DIV_RE;
               end
            end else begin
               ovf_in = ovf_ff | o1 | o2;
               if (op_ff == cau_pkg::OP_POW && cnt_ff > EW'(1)) begin
                  xr_in = cr; xi_in = ci;
                  cnt_in = cnt_ff - EW'(1);
                  state_in = cau_pkg::ST_MUL_A;
               end else begin
                  orr_in = cr; ori_in = ci;
                  ost_in = (ovf_ff | o1 | o2) ? cau_pkg::STATUS_OVF : cau_pkg::STATUS_OK;
                  state_in = cau_pkg::ST_DONE;
               end
            end
         end
         cau_pkg::ST_DIV_RE: begin
            if (!div_busy) begin
               qre_in = cq;
               ov_in = o3;
               nre_in = nim_ff;
               div_start = 1'b1;
               div_num = NW'(s1_ff[SW-1] ? -s1_ff : s1_ff) << FRAC_BITS;
               state_in = cau_pkg::ST_DIV_IM;
            end
         end
         cau_pkg::ST_DIV_IM: begin
            if (!div_busy) begin
               orr_in = qre_ff;
               ori_in = cq;
               ost_in = (ov_ff | o3) ? cau_pkg::STATUS_OVF : cau_pkg::STATUS_OK;
               state_in = cau_pkg::ST_DONE;
            end
         end
         cau_pkg::ST_DONE: begin
            if (out_ready) begin
               state_in = cau_pkg::ST_IDLE;
            end
         end
         default: state_in = cau_pkg::ST_IDLE;
      endcase
   end
endmodule

/* src/complex_arithmetic_unit.sv */
// complex arithmetic unit top level
//  channel  dir  handshake              payload
//  req      in   req_valid/req_ready    func a_real a_imag b_real b_imag exponent
//  rsp      out  rsp_valid/rsp_ready    res_real res_imag status
// add and subtract: result computed on entry, held in the queue, then passed through the sequencer
// multiply: product steps on the one shared multiplier; power: one multiply per exponent step beyond the first
// divide: denominator and numerators on the multiplier, then both quotients in the bit-serial divider
// one item in the back end at a time; the two-entry queue takes requests meanwhile
// synchronous reset clears control only; a stalled rsp holds the back end
module complex_arithmetic_unit #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16,
   parameter int MAX_EXPONENT = 255
) (
   input logic clock,
   input logic reset,
   cau_if.sink req,
   cau_if.source rsp
);
   localparam int EW = $clog2(MAX_EXPONENT + 1) + 1;

   logic q_valid, q_ready;
   cau_pkg::op_type q_op;
   logic signed [WORD_BITS-1:0] q_ar, q_ai, q_br, q_bi, q_rr, q_ri;
   logic [EW-1:0] q_exp;
   logic [cau_pkg::STATUS_BITS-1:0] q_st;

   cau_front #(.WORD_BITS(WORD_BITS), .MAX_EXPONENT(MAX_EXPONENT), .EW(EW)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .in_func(req.data.func), .in_ar(req.data.a_real), .in_ai(req.data.a_imag),
      .in_br(req.data.b_real), .in_bi(req.data.b_imag), .in_exp(req.data.exponent),
      .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op),
      .q_ar(q_ar), .q_ai(q_ai), .q_br(q_br), .q_bi(q_bi), .q_exp(q_exp),
      .q_rr(q_rr), .q_ri(q_ri), .q_st(q_st)
   );

   cau_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS), .EW(EW)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op),
      .q_ar(q_ar), .q_ai(q_ai), .q_br(q_br), .q_bi(q_bi), .q_exp(q_exp),
      .q_rr(q_rr), .q_ri(q_ri), .q_st(q_st),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_rr(rsp.data.res_real), .out_ri(rsp.data.res_imag), .out_st(rsp.data.status)
   );
endmodule

/* src/cau_checker.sv */
// port checker for the complex arithmetic unit, bound to the top level
`include "complex_arithmetic_unit_defines.svh"
module cau_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_status,
   input logic [31:0] rsp_res_real,
   input logic [31:0] rsp_res_imag
);
   logic rsp_waiting, rsp_div0, rsp_zero;
   assign rsp_waiting = rsp_valid && !rsp_ready;
   assign rsp_div0 = rsp_valid && (rsp_status == cau_pkg::STATUS_DIV0);
   assign rsp_zero = (rsp_res_real == 32'd0) && (rsp_res_imag == 32'd0);

   `CAU_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_waiting, rsp_valid && $stable(rsp_res_real))
   `CAU_ASSERT_NXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid)
   `CAU_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, rsp_status <= cau_pkg::STATUS_DIV0)
   `CAU_ASSERT_IMP(a_div0_zero, clock, reset, rsp_div0, rsp_zero)
   `CAU_ASSERT_NXT(a_no_rsp_after_reset, clock, 1'b0, reset, !rsp_valid)
endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.data.status),
   .rsp_res_real(rsp.data.res_real), .rsp_res_imag(rsp.data.res_imag)
);
